// ----- hw/rtl/msf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the Metropolis spin flip step block.
// Holds the microcode control word, result bundle and threshold bank types.
package msf_pkg;

    localparam int SIDE_DEFAULT = 64;

    localparam int KIND_W     = 2;
    localparam int COORD_IN_W = 6;
    localparam int COORD_IN_N = 1 << COORD_IN_W;
    localparam int CELL_W     = 2;
    localparam int DRAW_W     = 32;
    localparam int DIFF_W     = 2;
    localparam int THR_W      = 33;
    localparam int NUM_THR    = 8;
    localparam int THR_IDX_W  = $clog2(NUM_THR);
    localparam int STEP_W     = 3;

    localparam int SPIN_BIT  = 0;
    localparam int FIXED_BIT = 1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(64'h1_0000_0000);

    typedef enum logic [KIND_W-1:0] {
        K_WRITE = 2'd0,
        K_READ  = 2'd1,
        K_FLIP  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        A_IN,
        A_SITE,
        A_LEFT,
        A_RIGHT,
        A_THIRD
    } t_addr_sel;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_WRITE,
        CAP_READ,
        CAP_SITE,
        CAP_NBR,
        CAP_DECIDE
    } t_cap;

    typedef enum logic [1:0] {
        J_GOTO,
        J_DISPATCH,
        J_EMIT
    } t_jmp;

    typedef struct packed {
        t_addr_sel         addr_sel;
        t_cap              cap;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic              accept;
        logic [KIND_W-1:0] kind;
        logic              slot_free;
    } t_seq_flags;

    typedef struct packed {
        logic [CELL_W-1:0] cell_now;
        logic              accepted;
        logic              status;
        logic [DIFF_W-1:0] diff;
    } t_result;

    typedef logic [NUM_THR-1:0][THR_W-1:0] t_thr_bank;

endpackage

// ----- hw/rtl/msf_ram.sv -----
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module msf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/msf_useq.sv -----
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control word ROM and jump logic.
// Depends on msf_pkg.
module msf_useq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  msf_pkg::t_seq_flags i_flags,
    output msf_pkg::t_ctrl      o_ctrl
);
    import msf_pkg::*;

    typedef enum logic [STEP_W-1:0] {
        S_IDLE,
        S_WR,
        S_RD,
        S_F1,
        S_F2,
        S_F3,
        S_F4,
        S_EMIT
    } t_step;

    t_step r_step;
    t_step n_step;
    t_ctrl ctrl;

    function automatic t_ctrl rom(input t_step step);
        t_ctrl w;
        unique case (step)
            S_IDLE: w = '{addr_sel: A_IN,    cap: CAP_NONE,   jmp: J_DISPATCH, target: S_IDLE};
            S_WR:   w = '{addr_sel: A_SITE,  cap: CAP_WRITE,  jmp: J_GOTO,     target: S_EMIT};
            S_RD:   w = '{addr_sel: A_SITE,  cap: CAP_READ,   jmp: J_GOTO,     target: S_EMIT};
            S_F1:   w = '{addr_sel: A_LEFT,  cap: CAP_SITE,   jmp: J_GOTO,     target: S_F2};
            S_F2:   w = '{addr_sel: A_RIGHT, cap: CAP_NBR,    jmp: J_GOTO,     target: S_F3};
            S_F3:   w = '{addr_sel: A_THIRD, cap: CAP_NBR,    jmp: J_GOTO,     target: S_F4};
            S_F4:   w = '{addr_sel: A_SITE,  cap: CAP_DECIDE, jmp: J_GOTO,     target: S_EMIT};
            S_EMIT: w = '{addr_sel: A_SITE,  cap: CAP_NONE,   jmp: J_EMIT,     target: S_IDLE};
        endcase
        return w;
    endfunction

    assign ctrl = rom(r_step);

    always_comb begin
        n_step = r_step;
        unique case (ctrl.jmp)
            J_GOTO: begin
                n_step = t_step'(ctrl.target);
            end
            J_DISPATCH: begin
                if (i_flags.accept) begin
                    unique case (t_kind'(i_flags.kind))
                        K_WRITE: n_step = S_WR;
                        K_FLIP:  n_step = S_F1;
                        K_READ:  n_step = S_RD;
                        default: n_step = S_RD;
                    endcase
                end
            end
            J_EMIT: begin
                if (i_flags.slot_free) begin
                    n_step = t_step'(ctrl.target);
                end
            end
            default: n_step = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = ctrl;

endmodule

// ----- hw/rtl/msf_dpath.sv -----
`timescale 1ns / 1ps
// Datapath: transaction capture, lattice addressing, lattice RAM, neighbor
// count and threshold decision. Depends on msf_pkg and msf_ram.
module msf_dpath #(
    parameter int SIDE = msf_pkg::SIDE_DEFAULT
) (
    input  logic                           i_clk,
    input  msf_pkg::t_ctrl                 i_ctrl,
    input  logic                           i_accept,
    input  logic [msf_pkg::COORD_IN_W-1:0] i_row,
    input  logic [msf_pkg::COORD_IN_W-1:0] i_col,
    input  logic [msf_pkg::CELL_W-1:0]     i_write_cell,
    input  logic [msf_pkg::DRAW_W-1:0]     i_uniform_draw,
    input  msf_pkg::t_thr_bank             i_thr,
    output msf_pkg::t_result               o_result
);
    import msf_pkg::*;

    localparam int CW    = $clog2(SIDE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;

    typedef logic [CW-1:0] t_coord;
    typedef t_coord [COORD_IN_N-1:0] t_mod_tab;

    function automatic t_mod_tab build_mod_tab();
        t_mod_tab tab;
        int cnt;
        cnt = 0;
        for (int i = 0; i < COORD_IN_N; i++) begin
            tab[i] = t_coord'(cnt);
            cnt = (cnt == SIDE - 1) ? 0 : cnt + 1;
        end
        return tab;
    endfunction

    localparam t_mod_tab MOD_TAB  = build_mod_tab();
    localparam t_coord   LAST     = t_coord'(SIDE - 1);
    localparam logic     SIDE_ODD = 1'(SIDE % 2);

    t_coord              r_row;
    t_coord              r_col;
    logic [CELL_W-1:0]   r_wcell;
    logic [DRAW_W-1:0]   r_draw;
    logic [CELL_W-1:0]   r_cell;
    logic                r_acc;
    logic                r_status;
    logic [DIFF_W-1:0]   r_diff;

    t_coord              row_m1;
    t_coord              row_p1;
    t_coord              col_m1;
    t_coord              col_p1;
    logic                odd;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       site_addr;
    logic [CELL_W-1:0]   rd_data;
    logic [DIFF_W-1:0]   diff_fin;
    logic [THR_IDX_W-1:0] thr_sel;
    logic                flip_ok;
    logic                mem_we;
    logic [CELL_W-1:0]   mem_wdata;

    assign row_m1    = (r_row == '0) ? LAST : r_row - t_coord'(1);
    assign row_p1    = (r_row == LAST) ? '0 : r_row + t_coord'(1);
    assign col_m1    = (r_col == '0) ? LAST : r_col - t_coord'(1);
    assign col_p1    = (r_col == LAST) ? '0 : r_col + t_coord'(1);
    assign odd       = r_col[0] ^ (SIDE_ODD & r_row[0]);
    assign site_addr = {r_row, r_col};

    always_comb begin
        unique case (i_ctrl.addr_sel)
            A_IN:    raddr = {MOD_TAB[i_row], MOD_TAB[i_col]};
            A_SITE:  raddr = site_addr;
            A_LEFT:  raddr = {r_row, col_m1};
            A_RIGHT: raddr = {r_row, col_p1};
            A_THIRD: raddr = odd ? {row_p1, col_m1} : {row_m1, col_p1};
            default: raddr = site_addr;
        endcase
    end

    assign diff_fin = r_diff + DIFF_W'(rd_data[SPIN_BIT] ^ r_cell[SPIN_BIT]);
    assign thr_sel  = {r_cell[SPIN_BIT] == odd, diff_fin};
    assign flip_ok  = !r_cell[FIXED_BIT] && ({1'b0, r_draw} < i_thr[thr_sel]);

    assign mem_we    = (i_ctrl.cap == CAP_WRITE) || ((i_ctrl.cap == CAP_DECIDE) && flip_ok);
    assign mem_wdata = (i_ctrl.cap == CAP_WRITE) ? r_wcell
                                                 : {1'b0, ~r_cell[SPIN_BIT]};

    msf_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_lattice (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (site_addr),
        .i_wdata (mem_wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_row   <= MOD_TAB[i_row];
            r_col   <= MOD_TAB[i_col];
            r_wcell <= i_write_cell;
            r_draw  <= i_uniform_draw;
        end
        unique case (i_ctrl.cap)
            CAP_NONE: begin
            end
            CAP_WRITE: begin
                r_cell   <= r_wcell;
                r_acc    <= 1'b0;
                r_status <= 1'b0;
                r_diff   <= '0;
            end
            CAP_READ, CAP_SITE: begin
                r_cell   <= rd_data;
                r_acc    <= 1'b0;
                r_status <= 1'b0;
                r_diff   <= '0;
            end
            CAP_NBR: begin
                r_diff <= diff_fin;
            end
            CAP_DECIDE: begin
                r_diff   <= diff_fin;
                r_status <= r_cell[FIXED_BIT];
                r_acc    <= flip_ok;
                if (flip_ok) begin
                    r_cell[SPIN_BIT] <= ~r_cell[SPIN_BIT];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result = '{cell_now: r_cell, accepted: r_acc, status: r_status, diff: r_diff};

endmodule

// ----- hw/rtl/metropolis_spin_flip_step.sv -----
`timescale 1ns / 1ps
// Top level of the Metropolis spin flip step block: threshold registers,
// result register and handshake. Depends on msf_pkg, msf_useq and msf_dpath.
//
// The block holds a SIDE x SIDE wrapped lattice of two-bit cells in one RAM.
// Each input transaction writes a cell, reads a cell or attempts a flip at a
// site; each produces exactly one result transaction. Both channels use
// valid and stall; a transaction moves when valid is high and stall is low.
// A small microcode program steps through the work on one lattice RAM with
// one read and one write port, one cell read per cycle.
// A write or a read passes through its access step and an emit step. A flip
// attempt reads the site and its three neighbors one after another, decides
// once the last neighbor is in and then emits. The input channel takes a new
// transaction while the previous result still waits in the output register;
// when the receiver stalls and that register is full, the sequencer holds at
// its final step until the result is taken. Thresholds are written through
// the configuration port; the user must do so only while idle, as the block
// itself does not enforce it. Reset clears the sequencer and the output valid
// and sets all thresholds to always accept; lattice contents are undefined
// until written.
module metropolis_spin_flip_step #(
    parameter int SIDE = msf_pkg::SIDE_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [msf_pkg::KIND_W-1:0]     i_kind,
    input  logic [msf_pkg::COORD_IN_W-1:0] i_row,
    input  logic [msf_pkg::COORD_IN_W-1:0] i_col,
    input  logic [msf_pkg::CELL_W-1:0]     i_write_cell,
    input  logic [msf_pkg::DRAW_W-1:0]     i_uniform_draw,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [msf_pkg::CELL_W-1:0]     o_cell_now,
    output logic                           o_accepted,
    output logic                           o_status,
    output logic [msf_pkg::DIFF_W-1:0]     o_differing_count,
    input  logic                           i_cfg_we,
    input  logic [msf_pkg::THR_IDX_W-1:0]  i_cfg_index,
    input  logic [msf_pkg::THR_W-1:0]      i_cfg_data
);
    import msf_pkg::*;

    t_ctrl      ctrl;
    t_seq_flags flags;
    t_result    result;
    t_result    r_out;
    logic       r_out_valid;
    t_thr_bank  r_thr;
    logic       accept;
    logic       slot_free;
    logic       emit;

    assign o_in_stall = (ctrl.jmp != J_DISPATCH);
    assign accept     = i_in_valid && !o_in_stall;
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign emit       = (ctrl.jmp == J_EMIT) && slot_free;

    assign flags = '{accept: accept, kind: i_kind, slot_free: slot_free};

    msf_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    msf_dpath #(
        .SIDE (SIDE)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_ctrl         (ctrl),
        .i_accept       (accept),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_write_cell   (i_write_cell),
        .i_uniform_draw (i_uniform_draw),
        .i_thr          (r_thr),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_THR; k++) begin
                r_thr[k] <= THR_RESET;
            end
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_thr[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cell_now        = r_out.cell_now;
    assign o_accepted        = r_out.accepted;
    assign o_status          = r_out.status;
    assign o_differing_count = r_out.diff;

endmodule

// ----- test/tb_metropolis_spin_flip_step.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for metropolis_spin_flip_step: it predicts every result from its own
// lattice and threshold copy and checks the result transactions in order. Depends on msf_pkg.
module tb_metropolis_spin_flip_step;
    import msf_pkg::*;

    localparam int SIDE = SIDE_DEFAULT;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int NBR_LEFT  = 0;
    localparam int NBR_RIGHT = 1;
    localparam int NBR_THIRD = 2;
    localparam logic [THR_W-1:0] THR_NEVER = '0;
    localparam logic [THR_W-1:0] THR_TOP   = '1;
    localparam logic [THR_W-1:0] THR_JUST_BELOW = 33'h0_FFFF_FFFF;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [COORD_IN_W-1:0] row;
        logic [COORD_IN_W-1:0] col;
        logic [CELL_W-1:0]     wcell;
        logic [DRAW_W-1:0]     draw;
    } t_site_op;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [KIND_W-1:0]     i_kind = '0;
    logic [COORD_IN_W-1:0] i_row = '0;
    logic [COORD_IN_W-1:0] i_col = '0;
    logic [CELL_W-1:0]     i_write_cell = '0;
    logic [DRAW_W-1:0]     i_uniform_draw = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [CELL_W-1:0]     o_cell_now;
    logic                  o_accepted;
    logic                  o_status;
    logic [DIFF_W-1:0]     o_differing_count;
    logic                  i_cfg_we = 1'b0;
    logic [THR_IDX_W-1:0]  i_cfg_index = '0;
    logic [THR_W-1:0]      i_cfg_data = '0;

    t_site_op       pending_ops[$];
    t_result        predicted_results[$];
    logic [CELL_W-1:0] lattice [SIDE*SIDE];
    bit             written [SIDE*SIDE];
    logic [THR_W-1:0] thresholds [NUM_THR];

    bit          op_taken = 1'b0;
    bit          calm = 1'b0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int unsigned mismatches = 0;
    int unsigned ops_sent = 0;
    int unsigned flips_accepted = 0;
    int unsigned flips_rejected = 0;
    int unsigned fixed_reports = 0;
    int unsigned settings_used = 0;

    metropolis_spin_flip_step #(.SIDE(SIDE)) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_kind(i_kind),
        .i_row(i_row),
        .i_col(i_col),
        .i_write_cell(i_write_cell),
        .i_uniform_draw(i_uniform_draw),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_cell_now(o_cell_now),
        .o_accepted(o_accepted),
        .o_status(o_status),
        .o_differing_count(o_differing_count),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int neighbor_index(int r, int c, int which);
        int nr;
        int nc;
        nr = r;
        nc = c;
        case (which)
            NBR_LEFT:  nc = c + SIDE - 1;
            NBR_RIGHT: nc = c + 1;
            default: begin
                if (((r * SIDE + c) % 2) == 1) begin
                    nr = r + 1;
                    nc = c + SIDE - 1;
                end else begin
                    nr = r + SIDE - 1;
                    nc = c + 1;
                end
            end
        endcase
        return (nr % SIDE) * SIDE + (nc % SIDE);
    endfunction

    function automatic t_result predict_site_op(t_site_op op);
        int r;
        int c;
        int site;
        int diff;
        int sel;
        logic [CELL_W-1:0] cur;
        logic spin;
        logic odd;
        t_result res;
        r = int'(op.row) % SIDE;
        c = int'(op.col) % SIDE;
        site = r * SIDE + c;
        res = '0;
        case (op.kind)
            K_WRITE: begin
                lattice[site] = op.wcell;
                res.cell_now = op.wcell;
            end
            K_FLIP: begin
                cur = lattice[site];
                spin = cur[SPIN_BIT];
                odd = site[0];
                diff = 0;
                for (int w = NBR_LEFT; w <= NBR_THIRD; w++) begin
                    diff += int'(lattice[neighbor_index(r, c, w)][SPIN_BIT] ^ spin);
                end
                res.diff = DIFF_W'(diff);
                if (cur[FIXED_BIT]) begin
                    res.status = 1'b1;
                    fixed_reports++;
                end else begin
                    sel = ((spin != odd) ? 0 : 4) + diff;
                    if ({1'b0, op.draw} < thresholds[sel]) begin
                        res.accepted = 1'b1;
                        cur[SPIN_BIT] = ~spin;
                        lattice[site] = cur;
                        flips_accepted++;
                    end else begin
                        flips_rejected++;
                    end
                end
                res.cell_now = cur;
            end
            default: res.cell_now = lattice[site];
        endcase
        return res;
    endfunction

    function automatic logic [CELL_W-1:0] random_cell();
        return {($urandom_range(0, 5) == 0), 1'($urandom_range(0, 1))};
    endfunction

    // Reads and flips only touch cells already written; missing ones get a random write first.
    task automatic queue_op(input logic [KIND_W-1:0] kind, input int r, input int c,
                            input logic [CELL_W-1:0] wcell, input logic [DRAW_W-1:0] draw);
        int needed [4];
        int n;
        t_site_op op;
        needed[0] = r * SIDE + c;
        n = (kind == K_WRITE) ? 0 : 1;
        if (kind == K_FLIP) begin
            for (int w = NBR_LEFT; w <= NBR_THIRD; w++) needed[w + 1] = neighbor_index(r, c, w);
            n = 4;
        end
        for (int k = 0; k < n; k++) begin
            if (!written[needed[k]]) begin
                op.kind = K_WRITE;
                op.row = COORD_IN_W'(needed[k] / SIDE);
                op.col = COORD_IN_W'(needed[k] % SIDE);
                op.wcell = random_cell();
                op.draw = $urandom();
                pending_ops.push_back(op);
                written[needed[k]] = 1'b1;
            end
        end
        op.kind = kind;
        op.row = COORD_IN_W'(r);
        op.col = COORD_IN_W'(c);
        op.wcell = wcell;
        op.draw = draw;
        pending_ops.push_back(op);
        if (kind == K_WRITE) written[needed[0]] = 1'b1;
    endtask

    function automatic logic [DRAW_W-1:0] random_draw();
        logic [DRAW_W-1:0] d;
        case ($urandom_range(0, 9))
            0: d = '0;
            1: d = '1;
            2: d = thresholds[$urandom_range(0, NUM_THR - 1)][DRAW_W-1:0];
            3: d = thresholds[$urandom_range(0, NUM_THR - 1)][DRAW_W-1:0] - 1'b1;
            default: d = $urandom();
        endcase
        return d;
    endfunction

    function automatic logic [THR_W-1:0] random_threshold();
        logic [THR_W-1:0] t;
        case ($urandom_range(0, 7))
            0: t = THR_NEVER;
            1: t = THR_RESET;
            2: t = THR_TOP;
            3: t = THR_JUST_BELOW;
            4: t = {1'b1, 32'($urandom())};
            default: t = {1'b0, 32'($urandom())};
        endcase
        return t;
    endfunction

    task automatic queue_random_ops(input int count);
        int pick;
        int r;
        int c;
        logic [KIND_W-1:0] kind;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) kind = K_WRITE;
            else if (pick < 32) kind = K_READ;
            else if (pick < 95) kind = K_FLIP;
            else kind = KIND_SPARE;
            if ($urandom_range(0, 4) == 0) begin
                r = $urandom_range(0, SIDE - 1);
                c = $urandom_range(0, SIDE - 1);
            end else begin
                r = (SIDE - 2 + $urandom_range(0, 4)) % SIDE;
                c = (SIDE - 3 + $urandom_range(0, 5)) % SIDE;
            end
            queue_op(kind, r, c, random_cell(), random_draw());
        end
    endtask

    task automatic program_thresholds(input logic [THR_W-1:0] vals [NUM_THR]);
        for (int k = 0; k < NUM_THR; k++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= THR_IDX_W'(k);
            i_cfg_data <= vals[k];
            thresholds[k] = vals[k];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_until_drained();
        while (pending_ops.size() != 0 || predicted_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predicted_results.push_back(predict_site_op(pending_ops.pop_front()));
            op_taken = 1'b1;
            ops_sent++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !op_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_ops.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 15) - 1;
                i_in_valid <= 1'b0;
            end else begin
                i_kind <= pending_ops[0].kind;
                i_row <= pending_ops[0].row;
                i_col <= pending_ops[0].col;
                i_write_cell <= pending_ops[0].wcell;
                i_uniform_draw <= pending_ops[0].draw;
                i_in_valid <= 1'b1;
            end
        end
        op_taken = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.cell_now = o_cell_now;
            got.accepted = o_accepted;
            got.status = o_status;
            got.diff = o_differing_count;
            if (predicted_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result transaction with none expected (cell %0d)",
                             $time, got.cell_now);
            end else begin
                want = predicted_results.pop_front();
                if (got.cell_now !== want.cell_now || got.accepted !== want.accepted
                        || got.status !== want.status || got.diff !== want.diff) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: expected cell %0d accepted %0d status %0d diff %0d,",
                                  " got cell %0d accepted %0d status %0d diff %0d"},
                                 $time, want.cell_now, want.accepted, want.status, want.diff,
                                 got.cell_now, got.accepted, got.status, got.diff);
                end
            end
        end
    end

    initial begin : run_phases
        logic [THR_W-1:0] thr_set [NUM_THR];
        for (int k = 0; k < SIDE * SIDE; k++) lattice[k] = '0;
        for (int k = 0; k < NUM_THR; k++) thresholds[k] = THR_RESET;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset thresholds always accept, even the largest draw.
        queue_op(K_WRITE, 0, 0, 2'b00, '0);
        queue_op(K_WRITE, 0, SIDE - 1, 2'b01, '0);
        queue_op(K_WRITE, 0, 1, 2'b01, '0);
        queue_op(K_WRITE, SIDE - 1, 1, 2'b01, '0);
        queue_op(K_FLIP, 0, 0, 2'b00, '1);
        queue_op(K_FLIP, 0, 0, 2'b00, '0);
        queue_op(K_WRITE, SIDE - 1, SIDE - 1, 2'b11, '1);
        queue_op(K_FLIP, SIDE - 1, SIDE - 1, 2'b00, '0);
        queue_op(K_WRITE, 1, 0, 2'b10, '0);
        queue_op(K_FLIP, 1, 0, 2'b00, '0);
        queue_op(K_READ, 0, 1, 2'b11, '1);
        queue_op(KIND_SPARE, 0, 0, 2'b11, '1);
        wait_until_drained();

        foreach (thr_set[k]) thr_set[k] = THR_NEVER;
        program_thresholds(thr_set);
        queue_op(K_FLIP, 0, 1, 2'b00, '0);
        wait_until_drained();

        foreach (thr_set[k]) thr_set[k] = THR_JUST_BELOW;
        program_thresholds(thr_set);
        queue_op(K_FLIP, 0, 0, 2'b00, '1);
        queue_op(K_FLIP, 0, 0, 2'b00, 32'hFFFF_FFFE);
        wait_until_drained();

        foreach (thr_set[k]) thr_set[k] = THR_TOP;
        program_thresholds(thr_set);
        queue_op(K_FLIP, 0, 1, 2'b00, '1);
        wait_until_drained();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) calm = 1'b1;
            foreach (thr_set[k]) thr_set[k] = random_threshold();
            program_thresholds(thr_set);
            queue_random_ops(85);
            if (ph == 1) begin
                // Long receiver hold-off while the sender keeps offering transactions.
                @(posedge i_clk);
                hold_left = 300;
            end
            wait_until_drained();
        end

        $display("Sent %0d transactions under %0d threshold settings.", ops_sent, settings_used);
        $display("Flips: %0d accepted, %0d rejected, %0d on fixed sites.",
                 flips_accepted, flips_rejected, fixed_reports);
        if (mismatches == 0 && predicted_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
